FILE: design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Operation and status codes, beat structs and the per-cell command set.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int unsigned FIELD_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DATA  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD        = 3'd0,
        CMD_SHIFT_BACK  = 3'd1,
        CMD_SHIFT_FRONT = 3'd2,
        CMD_PUSH_BACK   = 3'd3,
        CMD_POP_BACK    = 3'd4,
        CMD_CLEAR       = 3'd5
    } t_cell_cmd;

    typedef struct packed {
        logic [2:0]             op;
        logic [FIELD_WIDTH-1:0] value;
    } t_in_beat;

    typedef struct packed {
        t_status                status;
        logic [FIELD_WIDTH-1:0] data;
    } t_out_beat;

    // neighbor view handed along the chain
    typedef struct packed {
        logic occ;
    } t_link;

endpackage

FILE: design/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one slot of the queue chain
// Holds one word and its occupancy flag; moves data to or from a neighbor.
// ----------------------------------------------------------------------------
module dq_cell
    import dq_pkg::*;
#(
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic [WORD_WIDTH-1:0] i_push_word,
    input  logic [WORD_WIDTH-1:0] i_left_word,
    input  t_link                 i_left,
    input  logic [WORD_WIDTH-1:0] i_right_word,
    input  t_link                 i_right,
    output logic [WORD_WIDTH-1:0] o_word,
    output t_link                 o_link,
    output logic [WORD_WIDTH-1:0] o_tail_word
);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;
    logic                  r_occ;
    logic                  n_occ;
    logic                  w_is_tail;
    logic                  w_is_free_next;

    assign w_is_tail      = r_occ & ~i_right.occ;
    assign w_is_free_next = ~r_occ & i_left.occ;

    always_comb begin
        n_word = r_word;
        n_occ  = r_occ;
        case (i_cmd)
            CMD_SHIFT_BACK: begin
                n_word = i_left_word;
                n_occ  = i_left.occ;
            end
            CMD_SHIFT_FRONT: begin
                n_word = i_right_word;
                n_occ  = i_right.occ;
            end
            CMD_PUSH_BACK: begin
                if (w_is_free_next) begin
                    n_word = i_push_word;
                    n_occ  = 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (w_is_tail) begin
                    n_occ = 1'b0;
                end
            end
            CMD_CLEAR: begin
                n_occ = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // word needs no reset: it is only read while occupied
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word      = r_word;
    assign o_link.occ  = r_occ;
    assign o_tail_word = w_is_tail ? r_word : '0;

endmodule

FILE: design/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue in a chain of cells
// Output: a result beat shows in the output register the cycle after accept.
// Throughput: one operation per cycle while the output is not stalled; every
//   operation is a single step of the cell chain, and the output register
//   frees up as its beat is taken.
// Reset: clears every occupancy flag and the output valid; stored words are
//   not reset and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    // The queue is kept front-aligned: cell 0 is always the front element,
    // and the occupancy flags form a thermometer code from cell 0 upward.
    // Push front shifts the chain one cell toward the back, pop front one
    // cell toward the front. Push back and pop back touch only the cell at
    // the edge of the thermometer, which each cell spots from its neighbor.

    logic [WORD_WIDTH-1:0] w_word      [DEPTH];
    logic [WORD_WIDTH-1:0] w_tail_word [DEPTH];
    t_link                 w_link      [DEPTH];
    logic [DEPTH-1:0]      w_occ;
    logic [WORD_WIDTH-1:0] w_push_word;
    logic [WORD_WIDTH-1:0] w_back_word;
    logic [WORD_WIDTH-1:0] w_sel_word;
    logic [FIELD_WIDTH-1:0] w_sel_data;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_accept;
    t_cell_cmd             w_dec_cmd;
    t_cell_cmd             w_cmd;
    t_status               w_status;
    logic                  w_use_back;

    t_out_beat             r_out_beat;
    t_out_beat             n_out_beat;
    logic                  r_out_valid;
    logic                  n_out_valid;

    // Take a new beat whenever the output register is empty or draining.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    // Fit the 32-bit field to the stored word width.
    generate
        if (WORD_WIDTH == FIELD_WIDTH) begin : g_push_same
            assign w_push_word = i_in_beat.value;
            assign w_sel_data  = w_sel_word;
        end else if (WORD_WIDTH < FIELD_WIDTH) begin : g_push_narrow
            assign w_push_word = i_in_beat.value[WORD_WIDTH-1:0];
            assign w_sel_data  = {{(FIELD_WIDTH-WORD_WIDTH){1'b0}}, w_sel_word};
        end else begin : g_push_wide
            assign w_push_word = {{(WORD_WIDTH-FIELD_WIDTH){1'b0}}, i_in_beat.value};
            assign w_sel_data  = w_sel_word[FIELD_WIDTH-1:0];
        end
    endgenerate

    // Build the cell chain.
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_WIDTH-1:0] w_left_word;
            logic [WORD_WIDTH-1:0] w_right_word;
            t_link                 w_left;
            t_link                 w_right;

            if (g == 0) begin : g_first
                // front neighbor: the incoming word, always counted as held
                assign w_left_word = w_push_word;
                assign w_left.occ  = 1'b1;
            end else begin : g_mid_left
                assign w_left_word = w_word[g-1];
                assign w_left      = w_link[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_right_word = '0;
                assign w_right.occ  = 1'b0;
            end else begin : g_mid_right
                assign w_right_word = w_word[g+1];
                assign w_right      = w_link[g+1];
            end

            dq_cell #(
                .WORD_WIDTH(WORD_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_push_word (w_push_word),
                .i_left_word (w_left_word),
                .i_left      (w_left),
                .i_right_word(w_right_word),
                .i_right     (w_right),
                .o_word      (w_word[g]),
                .o_link      (w_link[g]),
                .o_tail_word (w_tail_word[g])
            );

            assign w_occ[g] = w_link[g].occ;
        end
    endgenerate

    assign w_empty = ~w_occ[0];
    assign w_full  = w_occ[DEPTH-1];

    // Only the tail cell drives a nonzero tail word: merge them.
    always_comb begin
        w_back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_word = w_back_word | w_tail_word[i];
        end
    end

    // Decode the operation into a chain command and a status.
    always_comb begin
        w_dec_cmd  = CMD_HOLD;
        w_status   = ST_OK;
        w_use_back = 1'b0;
        unique case (i_in_beat.op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_dec_cmd = CMD_SHIFT_BACK;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_dec_cmd = CMD_PUSH_BACK;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_status  = ST_DATA;
                    w_dec_cmd = CMD_SHIFT_FRONT;
                end
            end
            OP_POP_BACK: begin
                w_use_back = 1'b1;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_status  = ST_DATA;
                    w_dec_cmd = CMD_POP_BACK;
                end
            end
            OP_PEEK_FRONT: begin
                w_status = w_empty ? ST_EMPTY : ST_DATA;
            end
            OP_PEEK_BACK: begin
                w_use_back = 1'b1;
                w_status   = w_empty ? ST_EMPTY : ST_DATA;
            end
            OP_CLEAR: begin
                w_dec_cmd = CMD_CLEAR;
            end
            default: begin
                // unused code: leave the queue alone, report ok
            end
        endcase
    end

    // Hold the chain unless a beat is taken this cycle.
    assign w_cmd      = w_accept ? w_dec_cmd : CMD_HOLD;
    assign w_sel_word = w_use_back ? w_back_word : w_word[0];

    // Output register: load on accept, drop valid once the beat is taken.
    always_comb begin
        n_out_beat  = r_out_beat;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_beat.status = w_status;
            n_out_beat.data   = (w_status == ST_DATA) ? w_sel_data : '0;
            n_out_valid       = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Occupancy must stay a thermometer code anchored at cell 0.
    a_occ_thermometer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ >> 1) & ~w_occ) == '0)
        else $error("occupancy flags have a hole");

    // A push into a queue with room grows it by exactly one entry.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full && (i_in_beat.op == OP_PUSH_FRONT ||
                                 i_in_beat.op == OP_PUSH_BACK))
        |=> $countones(w_occ) == $past($countones(w_occ)) + 1)
        else $error("push did not add one entry");

    // A pop from a non-empty queue shrinks it by exactly one entry.
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_empty && (i_in_beat.op == OP_POP_FRONT ||
                                  i_in_beat.op == OP_POP_BACK))
        |=> $countones(w_occ) + 1 == $past($countones(w_occ)))
        else $error("pop did not remove one entry");

    // Reads on an empty queue report the empty error.
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_empty && (i_in_beat.op == OP_POP_FRONT ||
            i_in_beat.op == OP_POP_BACK || i_in_beat.op == OP_PEEK_FRONT ||
            i_in_beat.op == OP_PEEK_BACK))
        |=> r_out_valid && r_out_beat.status == ST_EMPTY)
        else $error("empty read not flagged");

    // Data is zero unless the status says it carries a word.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.status != ST_DATA) |-> r_out_beat.data == '0)
        else $error("data present without data status");

endmodule
